FILE: rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants of the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int SQRT_STEPS = 63;
    localparam int DIV_STEPS  = 50;
    localparam int NDIV_STEPS = 17;

    // s1..s6, square root stages, r1, divider stages, f1 m1..m4,
    // normal divider stages, output register
    localparam int PIPE_DEPTH = 6 + (SQRT_STEPS + 1) + 1 + (DIV_STEPS + 1) + 5
                              + (NDIV_STEPS + 1) + 1;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS,
        REG_MIN_DIST
    } reg_idx_t;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] diff_t;

    typedef struct packed {
        coord_t [2:0] o;
        coord_t [2:0] d;
        diff_t  [2:0] tx;
    } ray_t;

    typedef struct packed {
        ray_t               ray;
        logic               ok;
        logic [63:0]        a;
        logic signed [66:0] h;
        logic [65:0]        rem;
        logic [62:0]        root;
        logic [125:0]       x;
    } sq_t;

    typedef struct packed {
        ray_t        ray;
        logic        ok;
        logic [63:0] a;
        logic        pos0;
        logic        pos1;
        logic        big0;
        logic        big1;
        logic [63:0] rem0;
        logic [63:0] rem1;
        logic [49:0] bits0;
        logic [49:0] bits1;
        logic [49:0] q0;
        logic [49:0] q1;
    } dv_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        hit_dist;
        coord_t [2:0]       point;
        logic [2:0]         nneg;
        logic [2:0]         nsat;
        logic [2:0][30:0]   rem;
        logic [2:0][16:0]   bits;
        logic [2:0][16:0]   q;
    } nd_t;

endpackage

FILE: rtl/ray_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// Fixed-point ray/sphere intersector: distance, unit normal and hit point.
// ----------------------------------------------------------------------------
// Accepts one ray per clock while s_tready is high and returns one result
// per ray, in order, on the master side through 146 register stages
// (counting the first one). The depth is set by the bit-per-stage square
// root of the discriminant (63 stages), the root dividers (50 stages, both
// roots in parallel) and the normal dividers (17 stages). When the result
// is not taken the whole pipeline holds and s_tready drops; nothing is lost.
// Sphere registers are written over the APB port while no ray is in flight;
// the user must keep to this, as the block itself does not enforce it.
module ray_sphere_intersect_unit
    import rsi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [191:0] s_tdata,
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance[30:0], normal_x/y/z (18 each), point_x/y/z (32 each), pad
    output logic [183:0] m_tdata,
    // is_hit
    output logic         m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    coord_t      center_reg [3];
    logic [30:0] radius_reg;
    logic [15:0] min_reg;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= 31'h10000;
            min_reg       <= 16'h0001;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (widx)
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                REG_RADIUS:   radius_reg    <= pwdata[30:0];
                REG_MIN_DIST: min_reg       <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            REG_MIN_DIST: prdata = {16'b0, min_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together
    // ------------------------------------------------------------------
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // step functions of the iterative units
    // ------------------------------------------------------------------
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t         n;
        logic [67:0] tv;
        logic [67:0] trial;
        n     = s;
        tv    = {s.rem, s.x[125:124]};
        trial = {3'b0, s.root, 2'b01};
        if (tv >= trial)
        begin
            n.rem  = 66'(tv - trial);
            n.root = {s.root[61:0], 1'b1};
        end
        else
        begin
            n.rem  = tv[65:0];
            n.root = {s.root[61:0], 1'b0};
        end
        n.x = {s.x[123:0], 2'b00};
        return n;
    endfunction

    function automatic dv_t div_step(input dv_t s);
        dv_t         n;
        logic [64:0] t0;
        logic [64:0] t1;
        logic        ge0;
        logic        ge1;
        n   = s;
        t0  = {s.rem0, s.bits0[49]};
        t1  = {s.rem1, s.bits1[49]};
        ge0 = t0 >= {1'b0, s.a};
        ge1 = t1 >= {1'b0, s.a};
        n.rem0  = ge0 ? 64'(t0 - {1'b0, s.a}) : t0[63:0];
        n.rem1  = ge1 ? 64'(t1 - {1'b0, s.a}) : t1[63:0];
        n.q0    = {s.q0[48:0], ge0};
        n.q1    = {s.q1[48:0], ge1};
        n.bits0 = {s.bits0[48:0], 1'b0};
        n.bits1 = {s.bits1[48:0], 1'b0};
        return n;
    endfunction

    function automatic nd_t ndiv_step(input nd_t s, input logic [30:0] r);
        nd_t         n;
        logic [31:0] t;
        logic        ge;
        n = s;
        for (int i = 0; i < 3; i++)
        begin
            t         = {s.rem[i], s.bits[i][16]};
            ge        = t >= {1'b0, r};
            n.rem[i]  = ge ? 31'(t - {1'b0, r}) : t[30:0];
            n.q[i]    = {s.q[i][15:0], ge};
            n.bits[i] = {s.bits[i][15:0], 1'b0};
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // s1: unpack, offset from center
    // ------------------------------------------------------------------
    ray_t s1_ray_reg;
    ray_t s1_ray_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_ray_next.o[i]  = s_tdata[32*i +: 32];
            s1_ray_next.d[i]  = s_tdata[96+32*i +: 32];
            s1_ray_next.tx[i] = 33'($signed(s_tdata[32*i +: 32]))
                              - 33'($signed(center_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_ray_reg <= s1_ray_next;
    end

    // ------------------------------------------------------------------
    // s2: per-axis products
    // ------------------------------------------------------------------
    ray_t               s2_ray_reg;
    logic signed [63:0] s2_dd_reg [3];
    logic signed [64:0] s2_td_reg [3];
    logic signed [65:0] s2_tt_reg [3];
    logic [61:0]        s2_rr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ray_reg <= s1_ray_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_dd_reg[i] <= $signed(s1_ray_reg.d[i]) * $signed(s1_ray_reg.d[i]);
                s2_td_reg[i] <= $signed(s1_ray_reg.tx[i]) * $signed(s1_ray_reg.d[i]);
                s2_tt_reg[i] <= $signed(s1_ray_reg.tx[i]) * $signed(s1_ray_reg.tx[i]);
            end
            s2_rr_reg <= 62'(radius_reg) * 62'(radius_reg);
        end
    end

    // ------------------------------------------------------------------
    // s3: a, half b, c
    // ------------------------------------------------------------------
    ray_t               s3_ray_reg;
    logic [63:0]        s3_a_reg;
    logic signed [66:0] s3_h_reg;
    logic signed [67:0] s3_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ray_reg <= s2_ray_reg;
            s3_a_reg   <= s2_dd_reg[0][63:0] + s2_dd_reg[1][63:0] + s2_dd_reg[2][63:0];
            s3_h_reg   <= 67'(s2_td_reg[0]) + 67'(s2_td_reg[1]) + 67'(s2_td_reg[2]);
            s3_c_reg   <= 68'(s2_tt_reg[0]) + 68'(s2_tt_reg[1]) + 68'(s2_tt_reg[2])
                        - $signed({6'b0, s2_rr_reg});
        end
    end

    // ------------------------------------------------------------------
    // s4: magnitudes for the wide products
    // ------------------------------------------------------------------
    ray_t               s4_ray_reg;
    logic [63:0]        s4_a_reg;
    logic signed [66:0] s4_h_reg;
    logic [65:0]        s4_habs_reg;
    logic [65:0]        s4_cabs_reg;
    logic               s4_cneg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ray_reg  <= s3_ray_reg;
            s4_a_reg    <= s3_a_reg;
            s4_h_reg    <= s3_h_reg;
            s4_habs_reg <= s3_h_reg[66] ? 66'(-s3_h_reg) : 66'(s3_h_reg);
            s4_cabs_reg <= s3_c_reg[67] ? 66'(-s3_c_reg) : 66'(s3_c_reg);
            s4_cneg_reg <= s3_c_reg[67];
        end
    end

    // ------------------------------------------------------------------
    // s5: partial products of h*h and a*c
    // ------------------------------------------------------------------
    ray_t               s5_ray_reg;
    logic [63:0]        s5_a_reg;
    logic signed [66:0] s5_h_reg;
    logic               s5_cneg_reg;
    logic [65:0]        s5_hh11_reg;
    logic [65:0]        s5_hh10_reg;
    logic [65:0]        s5_hh00_reg;
    logic [65:0]        s5_ac11_reg;
    logic [63:0]        s5_ac10_reg;
    logic [65:0]        s5_ac01_reg;
    logic [63:0]        s5_ac00_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ray_reg  <= s4_ray_reg;
            s5_a_reg    <= s4_a_reg;
            s5_h_reg    <= s4_h_reg;
            s5_cneg_reg <= s4_cneg_reg;
            s5_hh11_reg <= 66'(s4_habs_reg[65:33]) * 66'(s4_habs_reg[65:33]);
            s5_hh10_reg <= 66'(s4_habs_reg[65:33]) * 66'(s4_habs_reg[32:0]);
            s5_hh00_reg <= 66'(s4_habs_reg[32:0]) * 66'(s4_habs_reg[32:0]);
            s5_ac11_reg <= 66'(s4_a_reg[63:32]) * 66'(s4_cabs_reg[65:32]);
            s5_ac10_reg <= 64'(s4_a_reg[63:32]) * 64'(s4_cabs_reg[31:0]);
            s5_ac01_reg <= 66'(s4_a_reg[31:0]) * 66'(s4_cabs_reg[65:32]);
            s5_ac00_reg <= 64'(s4_a_reg[31:0]) * 64'(s4_cabs_reg[31:0]);
        end
    end

    // ------------------------------------------------------------------
    // s6: sum the partial products
    // ------------------------------------------------------------------
    ray_t               s6_ray_reg;
    logic [63:0]        s6_a_reg;
    logic signed [66:0] s6_h_reg;
    logic               s6_cneg_reg;
    logic [131:0]       s6_h2_reg;
    logic [129:0]       s6_ac_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_ray_reg  <= s5_ray_reg;
            s6_a_reg    <= s5_a_reg;
            s6_h_reg    <= s5_h_reg;
            s6_cneg_reg <= s5_cneg_reg;
            s6_h2_reg   <= {s5_hh11_reg, 66'b0} + 132'({s5_hh10_reg, 34'b0})
                         + 132'(s5_hh00_reg);
            s6_ac_reg   <= {s5_ac11_reg, 64'b0} + 130'({s5_ac10_reg, 32'b0})
                         + 130'({s5_ac01_reg, 32'b0}) + 130'(s5_ac00_reg);
        end
    end

    // ------------------------------------------------------------------
    // s7 and square root stages
    // ------------------------------------------------------------------
    sq_t          sq_reg [SQRT_STEPS+1];
    sq_t          sq0_next;
    logic [132:0] disc;

    always_comb
    begin
        disc = s6_cneg_reg ? 133'(s6_h2_reg) + 133'(s6_ac_reg)
                           : 133'(s6_h2_reg) - 133'(s6_ac_reg);
        sq0_next.ray  = s6_ray_reg;
        sq0_next.ok   = (s6_a_reg != '0) && !disc[132];
        sq0_next.a    = s6_a_reg;
        sq0_next.h    = s6_h_reg;
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        sq0_next.x    = disc[125:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sq_reg[0] <= sq0_next;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // r1: both root numerators
    // ------------------------------------------------------------------
    ray_t               r1_ray_reg;
    logic               r1_ok_reg;
    logic [63:0]        r1_a_reg;
    logic signed [67:0] r1_num0_reg;
    logic signed [67:0] r1_num1_reg;
    logic signed [67:0] h_ext;
    logic signed [67:0] e_ext;

    assign h_ext = 68'($signed(sq_reg[SQRT_STEPS].h));
    assign e_ext = $signed({5'b0, sq_reg[SQRT_STEPS].root});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_ray_reg  <= sq_reg[SQRT_STEPS].ray;
            r1_ok_reg   <= sq_reg[SQRT_STEPS].ok;
            r1_a_reg    <= sq_reg[SQRT_STEPS].a;
            r1_num0_reg <= -h_ext - e_ext;
            r1_num1_reg <= -h_ext + e_ext;
        end
    end

    // ------------------------------------------------------------------
    // root dividers, quotient limited to 50 bits
    // ------------------------------------------------------------------
    dv_t dv_reg [DIV_STEPS+1];
    dv_t dv0_next;

    always_comb
    begin
        dv0_next.ray   = r1_ray_reg;
        dv0_next.ok    = r1_ok_reg;
        dv0_next.a     = r1_a_reg;
        dv0_next.pos0  = !r1_num0_reg[67] && (r1_num0_reg != '0);
        dv0_next.pos1  = !r1_num1_reg[67] && (r1_num1_reg != '0);
        dv0_next.big0  = {31'b0, r1_num0_reg[66:34]} >= r1_a_reg;
        dv0_next.big1  = {31'b0, r1_num1_reg[66:34]} >= r1_a_reg;
        dv0_next.rem0  = {31'b0, r1_num0_reg[66:34]};
        dv0_next.rem1  = {31'b0, r1_num1_reg[66:34]};
        dv0_next.bits0 = {r1_num0_reg[33:0], 16'b0};
        dv0_next.bits1 = {r1_num1_reg[33:0], 16'b0};
        dv0_next.q0    = '0;
        dv0_next.q1    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv0_next;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[k+1] <= div_step(dv_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // f1: pick the root
    // ------------------------------------------------------------------
    ray_t        f1_ray_reg;
    logic        f1_hit_reg;
    logic [49:0] f1_t_reg;
    logic [49:0] t0;
    logic [49:0] t1;
    logic        fnd0;
    logic        fnd1;

    always_comb
    begin
        // a quotient that would pass 50 bits saturates the point and normal
        // anyway, so it is held at the top of the range
        t0   = dv_reg[DIV_STEPS].big0 ? '1 : dv_reg[DIV_STEPS].q0;
        t1   = dv_reg[DIV_STEPS].big1 ? '1 : dv_reg[DIV_STEPS].q1;
        fnd0 = dv_reg[DIV_STEPS].pos0 && (t0 > 50'(min_reg));
        fnd1 = dv_reg[DIV_STEPS].pos1 && (t1 > 50'(min_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_ray_reg <= dv_reg[DIV_STEPS].ray;
            f1_hit_reg <= dv_reg[DIV_STEPS].ok && (fnd0 || fnd1);
            f1_t_reg   <= fnd0 ? t0 : t1;
        end
    end

    // ------------------------------------------------------------------
    // m1..m4: step along the ray, point and normal numerator
    // ------------------------------------------------------------------
    ray_t               m1_ray_reg;
    logic               m1_hit_reg;
    logic [30:0]        m1_dist_reg;
    logic signed [57:0] m1_p1_reg [3];
    logic signed [57:0] m1_p0_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_ray_reg  <= f1_ray_reg;
            m1_hit_reg  <= f1_hit_reg;
            m1_dist_reg <= (f1_t_reg > 50'h7FFF_FFFF) ? 31'h7FFF_FFFF : f1_t_reg[30:0];
            for (int i = 0; i < 3; i++)
            begin
                m1_p1_reg[i] <= $signed({1'b0, f1_t_reg[49:25]}) * $signed(f1_ray_reg.d[i]);
                m1_p0_reg[i] <= $signed({1'b0, f1_t_reg[24:0]}) * $signed(f1_ray_reg.d[i]);
            end
        end
    end

    ray_t               m2_ray_reg;
    logic               m2_hit_reg;
    logic [30:0]        m2_dist_reg;
    logic signed [66:0] m2_step_reg [3];
    logic signed [82:0] prod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod[i] = (83'(m1_p1_reg[i]) <<< 25) + 83'(m1_p0_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_ray_reg  <= m1_ray_reg;
            m2_hit_reg  <= m1_hit_reg;
            m2_dist_reg <= m1_dist_reg;
            for (int i = 0; i < 3; i++)
                m2_step_reg[i] <= prod[i][82:16];
        end
    end

    logic               m3_hit_reg;
    logic [30:0]        m3_dist_reg;
    logic signed [67:0] m3_nn_reg [3];
    logic signed [67:0] m3_pt_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_hit_reg  <= m2_hit_reg;
            m3_dist_reg <= m2_dist_reg;
            for (int i = 0; i < 3; i++)
            begin
                m3_nn_reg[i] <= 68'($signed(m2_ray_reg.tx[i])) + 68'(m2_step_reg[i]);
                m3_pt_reg[i] <= 68'($signed(m2_ray_reg.o[i])) + 68'(m2_step_reg[i]);
            end
        end
    end

    logic        m4_hit_reg;
    logic [30:0] m4_dist_reg;
    logic [66:0] m4_nabs_reg [3];
    logic [2:0]  m4_nneg_reg;
    coord_t      m4_pt_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_hit_reg  <= m3_hit_reg;
            m4_dist_reg <= m3_dist_reg;
            for (int i = 0; i < 3; i++)
            begin
                m4_nneg_reg[i] <= m3_nn_reg[i][67];
                m4_nabs_reg[i] <= m3_nn_reg[i][67] ? 67'(-m3_nn_reg[i]) : 67'(m3_nn_reg[i]);
                if ((m3_pt_reg[i][67:31] == '0) || (m3_pt_reg[i][67:31] == '1))
                    m4_pt_reg[i] <= m3_pt_reg[i][31:0];
                else
                    m4_pt_reg[i] <= m3_pt_reg[i][67] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
    end

    // ------------------------------------------------------------------
    // m5 and normal dividers
    // ------------------------------------------------------------------
    nd_t nd_reg [NDIV_STEPS+1];
    nd_t nd0_next;

    always_comb
    begin
        nd0_next.hit      = m4_hit_reg;
        nd0_next.hit_dist = m4_dist_reg;
        nd0_next.nneg     = m4_nneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            nd0_next.point[i] = m4_pt_reg[i];
            // |n| >= 2r means the quotient reaches the Q1.16 limit
            nd0_next.nsat[i]  = m4_nabs_reg[i] >= {35'b0, radius_reg, 1'b0};
            nd0_next.rem[i]   = m4_nabs_reg[i][31:1];
            nd0_next.bits[i]  = {m4_nabs_reg[i][0], 16'b0};
            nd0_next.q[i]     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            nd_reg[0] <= nd0_next;
    end

    for (genvar k = 0; k < NDIV_STEPS; k++)
    begin : g_ndiv
        always_ff @(posedge clk)
        begin
            if (adv)
                nd_reg[k+1] <= ndiv_step(nd_reg[k], radius_reg);
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [17:0]  nrm [3];
    logic [183:0] out_data_next;
    logic [183:0] out_data_reg;
    logic         out_hit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            priority if (radius_reg == '0)
                nrm[i] = '0;
            else if (nd_reg[NDIV_STEPS].nsat[i])
                nrm[i] = nd_reg[NDIV_STEPS].nneg[i] ? 18'h2_0000 : 18'h1_FFFF;
            else if (nd_reg[NDIV_STEPS].nneg[i])
                nrm[i] = 18'(-{1'b0, nd_reg[NDIV_STEPS].q[i]});
            else
                nrm[i] = {1'b0, nd_reg[NDIV_STEPS].q[i]};
        end
        out_data_next = {3'b0,
                         nd_reg[NDIV_STEPS].point[2],
                         nd_reg[NDIV_STEPS].point[1],
                         nd_reg[NDIV_STEPS].point[0],
                         nrm[2], nrm[1], nrm[0],
                         nd_reg[NDIV_STEPS].hit_dist};
        // a miss reports all zeros
        if (!nd_reg[NDIV_STEPS].hit)
            out_data_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_hit_reg  <= nd_reg[NDIV_STEPS].hit;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_hit_reg;

endmodule
